### design/v3au_pkg.sv
package v3au_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_NEG  = 4'd2;
  localparam logic [3:0] OP_SCL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_DOT  = 4'd5;
  localparam logic [3:0] OP_SQR  = 4'd6;
  localparam logic [3:0] OP_MAG  = 4'd7;
  localparam logic [3:0] OP_NRM  = 4'd8;
  localparam logic [3:0] OP_CRS  = 4'd9;

  typedef struct packed {
    logic [3:0]   mode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_k;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               saturated;
    logic               div_error;
  } out_beat_t;

endpackage

### design/v3au_sqrt.sv
// Pipelined integer square root of a 66-bit value, one result bit per stage.
module v3au_sqrt #(
  parameter int unsigned W = 66
) (
  input  logic             clk_i,
  input  logic [W-1:0]     val_i,
  output logic [W/2-1:0]   root_o
);
  localparam int unsigned N = W / 2;

  logic [W-1:0]   rem_q  [N+1];
  logic [N-1:0]   res_q  [N+1];

  always_comb begin
    rem_q[0] = val_i;
    res_q[0] = '0;
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [N+1:0] trial;
    logic [N+1:0] part;
    logic [W-1:0] rem_d;
    logic [N-1:0] res_d;
    always_comb begin
      part  = (N+2)'(rem_q[s] >> (2 * (N - 1 - s)));
      trial = {res_q[s], 2'b01};
      rem_d = rem_q[s];
      res_d = {res_q[s][N-2:0], 1'b0};
      if (part >= trial) begin
        rem_d = rem_q[s] - (W'(trial) << (2 * (N - 1 - s)));
        res_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      res_q[s+1] <= res_d;
    end
  end

  assign root_o = res_q[N];
endmodule

### design/v3au_div.sv
// Pipelined restoring divider: quotient of a 48-bit numerator by a 33-bit divisor.
module v3au_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);
  logic [NW-1:0] q_q [NW+1];
  logic [DW-1:0] r_q [NW+1];
  logic [DW-1:0] d_q [NW+1];

  always_comb begin
    q_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW:0] sh;
    logic [DW:0] df;
    always_comb begin
      sh = {r_q[s], q_q[s][NW-1]};
      df = sh - {1'b0, d_q[s]};
    end
    always_ff @(posedge clk_i) begin
      d_q[s+1] <= d_q[s];
      if (!df[DW]) begin
        r_q[s+1] <= df[DW-1:0];
        q_q[s+1] <= {q_q[s][NW-2:0], 1'b1};
      end else begin
        r_q[s+1] <= sh[DW-1:0];
        q_q[s+1] <= {q_q[s][NW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = q_q[NW];
endmodule

### design/vector3_arithmetic_unit_top.sv
// Fully pipelined three-vector unit: a beat may start in every cycle (busy is
// always low) and its result is presented with done_o for one cycle. The
// depth is set by one product stage, one sum and clip stage, the bit-per-stage
// square root (33 stages), the bit-per-stage divider (32 + FRAC_BITS stages) and
// the output register; every operation takes the same path. The receiver cannot
// stall, so every result must be taken in its cycle.
module vector3_arithmetic_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  v3au_pkg::in_beat_t   in_i,
  output logic                 done_o,
  output v3au_pkg::out_beat_t  out_o
);
  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned SQL = 33;
  localparam int unsigned LAT = 2 + SQL + NW;
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  assign busy = 1'b0;

  // Stage 1: products.
  logic [LAT-1:0] vld_q;
  v3au_pkg::in_beat_t in1_q;
  logic signed [63:0] p_q [9];
  logic [63:0]        sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[LAT-2:0], start};
  end

  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  always_comb begin
    av[0] = in_i.a_x; av[1] = in_i.a_y; av[2] = in_i.a_z;
    bv[0] = in_i.b_x; bv[1] = in_i.b_y; bv[2] = in_i.b_z;
  end

  always_ff @(posedge clk_i) begin
    in1_q <= in_i;
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] aa;
      aa = av[i] * av[i];
      p_q[i]   <= (in_i.mode == v3au_pkg::OP_SCL) ? av[i] * in_i.scalar_k :
                  (in_i.mode == v3au_pkg::OP_SQR) ? aa : av[i] * bv[i];
      sq_q[i]  <= aa;
    end
    p_q[3] <= av[1] * bv[2]; p_q[4] <= av[2] * bv[1];
    p_q[5] <= av[2] * bv[0]; p_q[6] <= av[0] * bv[2];
    p_q[7] <= av[0] * bv[1]; p_q[8] <= av[1] * bv[0];
  end

  // Stage 2: sums, shifted and clipped; sqrt operand.
  v3au_pkg::in_beat_t in2_q;
  logic signed [31:0] sm_q [4];
  logic               smsat_q [4];
  logic [65:0]        s_q;

  function automatic logic signed [32:0] clipf(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v >>> FRAC_BITS;
    if (t > 68'(MAXV))      clipf = {1'b1, 32'h7fffffff};
    else if (t < 68'(MINV)) clipf = {1'b1, 32'h80000000};
    else                    clipf = {1'b0, t[31:0]};
  endfunction

  always_ff @(posedge clk_i) begin
    logic signed [32:0] c;
    in2_q <= in1_q;
    s_q <= 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
    if (in1_q.mode == v3au_pkg::OP_CRS) begin
      c = clipf(68'(p_q[3]) - 68'(p_q[4])); sm_q[0] <= c[31:0]; smsat_q[0] <= c[32];
      c = clipf(68'(p_q[5]) - 68'(p_q[6])); sm_q[1] <= c[31:0]; smsat_q[1] <= c[32];
      c = clipf(68'(p_q[7]) - 68'(p_q[8])); sm_q[2] <= c[31:0]; smsat_q[2] <= c[32];
    end else begin
      for (int i = 0; i < 3; i++) begin
        c = clipf(68'(p_q[i])); sm_q[i] <= c[31:0]; smsat_q[i] <= c[32];
      end
    end
    c = clipf(68'(p_q[0]) + 68'(p_q[1]) + 68'(p_q[2]));
    sm_q[3] <= c[31:0]; smsat_q[3] <= c[32];
  end

  // Square root pipeline with matching delay line.
  logic [32:0] root;
  v3au_sqrt #(.W(66)) u_sqrt (.clk_i(clk_i), .val_i(s_q), .root_o(root));

  typedef struct packed {
    v3au_pkg::in_beat_t b;
    logic [127:0] sm;
    logic [3:0]   ss;
  } dly_t;
  dly_t d2, dq [SQL+1];
  assign d2.b  = in2_q;
  assign d2.sm = {sm_q[3], sm_q[2], sm_q[1], sm_q[0]};
  assign d2.ss = {smsat_q[3], smsat_q[2], smsat_q[1], smsat_q[0]};
  assign dq[0] = d2;
  for (genvar s = 0; s < SQL; s++) begin : g_d1
    always_ff @(posedge clk_i) dq[s+1] <= dq[s];
  end
  dly_t d3;
  assign d3 = dq[SQL];

  // Divider operands.
  logic [32:0] den;
  logic [31:0] num_m [3];
  logic signed [31:0] a3 [3];
  assign a3[0] = d3.b.a_x; assign a3[1] = d3.b.a_y; assign a3[2] = d3.b.a_z;
  assign den = (d3.b.mode == v3au_pkg::OP_DIV) ?
               (d3.b.scalar_k[31] ? 33'(-34'(d3.b.scalar_k)) : 33'(d3.b.scalar_k)) : root;

  logic [NW-1:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_dv
    logic [32:0] mg;
    assign mg = a3[i][31] ? 33'(-34'(a3[i])) : 33'(a3[i]);
    v3au_div #(.NW(NW), .DW(33)) u_div (
      .clk_i(clk_i), .num_i(NW'(mg) << FRAC_BITS), .den_i(den), .quo_o(quo[i]));
  end

  typedef struct packed {
    dly_t d;
    logic [32:0] rt;
  } dl2_t;
  dl2_t eq [NW+1];
  assign eq[0] = '{d: d3, rt: root};
  for (genvar s = 0; s < NW; s++) begin : g_d2
    always_ff @(posedge clk_i) eq[s+1] <= eq[s];
  end
  dl2_t e;
  assign e = eq[NW];

  // Final select and output register.
  v3au_pkg::out_beat_t res_d, res_q;
  logic done_q;
  logic signed [31:0] ae [3];
  logic signed [31:0] be [3];
  assign ae[0] = e.d.b.a_x; assign ae[1] = e.d.b.a_y; assign ae[2] = e.d.b.a_z;
  assign be[0] = e.d.b.b_x; assign be[1] = e.d.b.b_y; assign be[2] = e.d.b.b_z;

  always_comb begin
    logic signed [32:0] r [3];
    logic signed [31:0] rs;
    logic sat, derr, kneg, neg;
    logic signed [33:0] t;
    for (int i = 0; i < 3; i++) r[i] = '0;
    rs = '0; sat = 1'b0; derr = 1'b0;
    t = '0; neg = 1'b0;
    kneg = e.d.b.scalar_k[31];
    case (e.d.b.mode)
      v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          if (e.d.b.mode == v3au_pkg::OP_ADD)      t = 34'(ae[i]) + 34'(be[i]);
          else if (e.d.b.mode == v3au_pkg::OP_SUB) t = 34'(ae[i]) - 34'(be[i]);
          else                                     t = -34'(ae[i]);
          if (t > 34'sd2147483647)       begin r[i] = 33'sd2147483647; sat = 1'b1; end
          else if (t < -34'sd2147483648) begin r[i] = -33'sd2147483648; sat = 1'b1; end
          else r[i] = 33'(t);
        end
      end
      v3au_pkg::OP_SCL, v3au_pkg::OP_CRS: begin
        r[0] = 33'(e.d.sm[31:0]); r[1] = 33'(e.d.sm[63:32]);
        r[2] = 33'(e.d.sm[95:64]);
        sat = |e.d.ss[2:0];
        for (int i = 0; i < 3; i++) r[i] = {r[i][31], r[i][31:0]};
      end
      v3au_pkg::OP_DOT, v3au_pkg::OP_SQR: begin
        rs = e.d.sm[127:96]; sat = e.d.ss[3];
      end
      v3au_pkg::OP_MAG: begin
        if (e.rt > 33'h07fffffff) begin rs = 32'h7fffffff; sat = 1'b1; end
        else rs = e.rt[31:0];
      end
      v3au_pkg::OP_DIV, v3au_pkg::OP_NRM: begin
        if (e.d.b.mode == v3au_pkg::OP_NRM && e.rt == '0) derr = 1'b1;
        else if (e.d.b.mode == v3au_pkg::OP_DIV && e.d.b.scalar_k == '0) begin
          derr = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (ae[i] > 0)      begin r[i] = 33'sd2147483647; sat = 1'b1; end
            else if (ae[i] < 0) begin r[i] = -33'sd2147483648; sat = 1'b1; end
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            neg = ae[i][31] ^ (e.d.b.mode == v3au_pkg::OP_DIV && kneg);
            if (quo[i] == '0) r[i] = '0;
            else if (neg) begin
              if (quo[i] > NW'(64'h80000000)) begin r[i] = -33'sd2147483648; sat = 1'b1; end
              else r[i] = -33'(quo[i][32:0]);
            end else begin
              if (quo[i] > NW'(64'h7fffffff)) begin r[i] = 33'sd2147483647; sat = 1'b1; end
              else r[i] = 33'(quo[i][32:0]);
            end
          end
        end
      end
      default: ;
    endcase
    res_d.r_x = r[0][31:0]; res_d.r_y = r[1][31:0]; res_d.r_z = r[2][31:0];
    res_d.r_scalar = rs; res_d.saturated = sat; res_d.div_error = derr;
  end

  always_ff @(posedge clk_i) res_q <= res_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vld_q[LAT-1];
  end

  assign done_o = done_q;
  assign out_o  = res_q;
endmodule

### design/v3au_checker.sv
module v3au_checker #(
  parameter int unsigned LAT = 83
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input v3au_pkg::out_beat_t out_o
);
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT + 1))
    else $error("result without a beat");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.div_error && out_o.r_scalar != 32'd0 |-> 1'b0)
    else $error("scalar set with division error");
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("done out of reset");
endmodule

bind vector3_arithmetic_unit_top v3au_checker #(.LAT(LAT)) u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .out_o(out_o));
